[sv/wpm_pkg.sv]
// Shared types and constants for the wildcard pattern matcher.
// Used by the match cells and the top level; no dependencies.
`default_nettype none

package wpm_pkg;

    localparam int SYM_W = 5;
    localparam logic [SYM_W-1:0] SYM_WILDCARD = 5'd26;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_TEXT    = 2'd1,
        OP_RESTART = 2'd2
    } t_opcode;

    // Control broadcast from the top level to every cell in the row.
    typedef struct packed {
        logic             text_en;
        logic             load_en;
        logic             clear;
        logic [SYM_W-1:0] letter;
        logic [5:0]       wr_index;
    } t_cell_ctrl;

endpackage

`default_nettype wire

[sv/wpm_cell.sv]
// One match cell: one pattern symbol and one bit of the match vector.
// Depends on wpm_pkg.
`default_nettype none

module wpm_cell
    import wpm_pkg::*;
#(
    parameter int IDX = 0
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire t_cell_ctrl  i_ctrl,
    input  wire              i_prev_match,
    output logic             o_match,
    output logic             o_next_match
);

    logic [SYM_W-1:0] r_sym;
    logic             r_match;
    logic             sym_hit;
    logic             wr_here;

    assign wr_here = i_ctrl.load_en && (32'(i_ctrl.wr_index) == IDX);
    assign sym_hit = (i_ctrl.letter < SYM_WILDCARD) &&
                     ((r_sym == SYM_WILDCARD) || (r_sym == i_ctrl.letter));

    always_comb begin
        if (i_ctrl.clear) begin
            o_next_match = 1'b0;
        end else if (i_ctrl.text_en) begin
            o_next_match = i_prev_match && sym_hit;
        end else begin
            o_next_match = r_match;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym   <= SYM_WILDCARD;
            r_match <= 1'b0;
        end else begin
            r_match <= o_next_match;
            if (wr_here) begin
                r_sym <= i_ctrl.letter;
            end
        end
    end

    assign o_match = r_match;

endmodule

`default_nettype wire

[sv/wpm_obuf.sv]
// Output register with one skid entry for the result channel.
// No package dependencies.
`default_nettype none

module wpm_obuf #(
    parameter int W = 32
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_res_valid,
    input  wire [W-1:0]  i_res_data,
    output logic         o_full,
    output logic         o_valid,
    input  wire          i_stall,
    output logic [W-1:0] o_data
);

    logic         r_out_v;
    logic [W-1:0] r_out;
    logic         r_skid_v;
    logic [W-1:0] r_skid;
    logic         out_fire;

    assign out_fire = r_out_v && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            // input is held off while the skid entry is occupied
            if (out_fire) begin
                r_out    <= r_skid;
                r_skid_v <= 1'b0;
            end
        end else if (!r_out_v || out_fire) begin
            r_out_v <= i_res_valid;
            r_out   <= i_res_data;
        end else if (i_res_valid) begin
            r_skid   <= i_res_data;
            r_skid_v <= 1'b1;
        end
    end

    assign o_full  = r_skid_v;
    assign o_valid = r_out_v;
    assign o_data  = r_out;

endmodule

`default_nettype wire

[sv/wildcard_pattern_matcher_top.sv]
// Top level of the wildcard pattern matcher: row of match cells plus output buffer.
// Depends on wpm_pkg, wpm_cell and wpm_obuf.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one item per accept:
//     OP_LOAD writes i_symbol at i_pattern_index and clears match progress;
//     OP_TEXT feeds one letter; OP_RESTART resets the text position to zero.
//   Output channel (o_out_valid / i_out_stall) carries the start position of
//     every full-length window that matches, at most one per text item.
//   Config channel (i_cfg_valid / o_cfg_ready) writes pattern_length; write it
//     only while idle. o_cfg_ready is always high.
// Throughput: one item per cycle while o_in_stall is low, set by the cell row, which
//   updates every match bit from its neighbor's stored bit on each text item.
// Result path: each result is registered (output register or skid) before o_out_valid.
// Stall: a stalled result holds in the output register; one more result fits
//   in the skid entry, and o_in_stall rises only while that entry is full.
// Reset: all pattern symbols are wildcards, length is 1, match vector and text
//   position are zero, both channels empty.
`default_nettype none

module wildcard_pattern_matcher_top
    import wpm_pkg::*;
#(
    parameter int PATTERN_MAX = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [1:0]  i_opcode,
    input  wire  [4:0]  i_symbol,
    input  wire  [5:0]  i_pattern_index,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [31:0] o_start_position,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [6:0]  i_cfg_data
);

    localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int LW = ($clog2(PATTERN_MAX + 1) > 7) ? $clog2(PATTERN_MAX + 1) : 7;

    logic [IW-1:0]          r_last;    // effective length minus one
    logic [IW-1:0]          n_last;
    logic [31:0]            r_pos;     // position of the next text letter
    logic [LW-1:0]          len_ext;
    logic [LW-1:0]          len_eff;
    logic                   in_fire;
    logic                   load_ok;
    logic                   res_valid;
    logic [31:0]            res_pos;
    t_opcode                op;
    t_cell_ctrl             ctrl;
    logic [PATTERN_MAX-1:0] match;
    logic [PATTERN_MAX-1:0] next_match;
    logic [PATTERN_MAX-1:0] prev_match;

    assign in_fire = i_in_valid && !o_in_stall;
    assign op      = t_opcode'(i_opcode);
    assign load_ok = (32'(i_pattern_index) < PATTERN_MAX);

    // Decode the item into the broadcast control for the cell row.
    always_comb begin
        ctrl          = '0;
        ctrl.letter   = i_symbol;
        ctrl.wr_index = i_pattern_index;
        if (in_fire) begin
            case (op)
                OP_LOAD: begin
                    ctrl.load_en = load_ok;
                    ctrl.clear   = load_ok;
                end
                OP_TEXT: begin
                    ctrl.text_en = 1'b1;
                end
                OP_RESTART: begin
                    ctrl.clear = 1'b1;
                end
                default: begin
                    // drop the unused opcode
                end
            endcase
        end
    end

    // Cell 0 always sees a match to its left; each other cell takes its
    // neighbor's stored bit.
    genvar k;
    generate
        for (k = 0; k < PATTERN_MAX; k++) begin : g_cell
            if (k == 0) begin : g_first
                assign prev_match[k] = 1'b1;
            end else begin : g_rest
                assign prev_match[k] = match[k-1];
            end

            wpm_cell #(
                .IDX (k)
            ) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (ctrl),
                .i_prev_match (prev_match[k]),
                .o_match      (match[k]),
                .o_next_match (next_match[k])
            );
        end
    endgenerate

    // Clamp the written length to 1..PATTERN_MAX and keep it as a bit index.
    always_comb begin
        len_ext = LW'(i_cfg_data);
        if (len_ext == '0) begin
            len_eff = LW'(1);
        end else if (len_ext > LW'(PATTERN_MAX)) begin
            len_eff = LW'(PATTERN_MAX);
        end else begin
            len_eff = len_ext;
        end
        n_last = IW'(len_eff - LW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
            r_pos  <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_last <= n_last;
            end
            if (in_fire && op == OP_TEXT) begin
                r_pos <= r_pos + 32'd1;
            end else if (in_fire && op == OP_RESTART) begin
                r_pos <= '0;
            end
        end
    end

    // A full window ends at this letter when the last pattern bit sets.
    assign res_valid = ctrl.text_en && next_match[r_last];
    assign res_pos   = r_pos - 32'(r_last);

    wpm_obuf #(
        .W (32)
    ) u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res_data  (res_pos),
        .o_full      (o_in_stall),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_data      (o_start_position)
    );

    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

[tb/wildcard_pattern_matcher_top_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for wildcard_pattern_matcher_top: directed items, then random phases.
// Depends on wpm_pkg and the matcher RTL; a scoreboard class predicts every start position.

module wildcard_pattern_matcher_top_tb;
    import wpm_pkg::*;

    localparam int PATTERN_MAX   = 64;
    localparam int LETTERS       = 26;
    localparam int ITEM_TARGET   = 1200;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int DRAIN_LIMIT   = 20_000;
    // Wait after the last result before touching the length register.
    localparam int SETTLE_CYCLES = 4;
    // Opcode 3 has no meaning in the package; the block must ignore it.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Scoreboard: own copy of the pattern store, match vector, text position and
    // length register; predicts the start position of every matching window.
    class match_scoreboard;
        logic [SYM_W-1:0]       pattern_sym [PATTERN_MAX];
        logic [PATTERN_MAX-1:0] window_hits;
        logic [31:0]            next_pos;
        logic [6:0]             length_reg;
        logic [31:0]            expected_starts [$];
        int unsigned            failures;

        function new();
            foreach (pattern_sym[k]) pattern_sym[k] = SYM_WILDCARD;
            window_hits = '0;
            next_pos    = '0;
            length_reg  = 7'd1;
            failures    = 0;
        endfunction

        function void write_length(logic [6:0] value);
            length_reg = value;
        endfunction

        function void note_item(logic [1:0] op, logic [SYM_W-1:0] sym, logic [5:0] idx);
            logic [PATTERN_MAX-1:0] mask;
            int                     last;
            int                     k;
            mask = '0;
            case (op)
                OP_LOAD: begin
                    pattern_sym[idx] = sym;
                    window_hits      = '0;
                end
                OP_RESTART: begin
                    window_hits = '0;
                    next_pos    = '0;
                end
                OP_TEXT: begin
                    // A non-letter matches nothing, not even a wildcard.
                    for (k = 0; k < PATTERN_MAX; k++)
                        if (sym < SYM_WILDCARD &&
                            (pattern_sym[k] == SYM_WILDCARD || pattern_sym[k] == sym))
                            mask[k] = 1'b1;
                    window_hits = ((window_hits << 1) | 1) & mask;
                    if (length_reg == 0)
                        last = 0;
                    else if (length_reg > PATTERN_MAX)
                        last = PATTERN_MAX - 1;
                    else
                        last = int'(length_reg) - 1;
                    if (window_hits[last])
                        expected_starts.insert(expected_starts.size(),
                                               next_pos - 32'(last));
                    next_pos = next_pos + 32'd1;
                end
                default: ;
            endcase
        endfunction

        function void check_start(logic [31:0] actual);
            logic [31:0] want;
            if (expected_starts.size() == 0) begin
                $error("start_position: no result expected, actual %0d", actual);
                failures++;
            end else begin
                want = expected_starts.pop_front();
                if (actual !== want) begin
                    $error("start_position: expected %0d, actual %0d", want, actual);
                    failures++;
                end
            end
        endfunction

        function void flag_leftovers();
            if (expected_starts.size() != 0) begin
                $error("start_position: %0d expected results never arrived",
                       expected_starts.size());
                failures++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic [1:0]  in_opcode  = 2'd0;
    logic [4:0]  in_symbol  = 5'd0;
    logic [5:0]  in_index   = 6'd0;
    logic        out_stall  = 1'b0;
    logic        cfg_valid  = 1'b0;
    logic [6:0]  cfg_data   = 7'd0;
    logic        in_stall;
    logic        out_valid;
    logic [31:0] start_pos;
    logic        cfg_ready;

    match_scoreboard sb;
    int unsigned     items_sent  = 0;
    int unsigned     cycle_count = 0;
    int unsigned     stall_left  = 0;

    wildcard_pattern_matcher_top DUT (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_opcode         (in_opcode),
        .i_symbol         (in_symbol),
        .i_pattern_index  (in_index),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_start_position (start_pos),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_data       (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Present one item at the falling edge and hold it until accepted.
    // Valid stays high on return, so back-to-back items need no extra step.
    task automatic send_item(logic [1:0] op, logic [4:0] sym, logic [5:0] idx);
        @(negedge clk);
        in_valid  <= 1'b1;
        in_opcode <= op;
        in_symbol <= sym;
        in_index  <= idx;
        do @(posedge clk); while (in_stall);
        if (op != OP_UNUSED)
            items_sent++;
    endtask

    // Drop valid for a gap of length n; n of zero leaves valid as it is.
    task automatic pause(int unsigned n);
        if (n > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic write_length(logic [6:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        sb.write_length(value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Hold the sender until every expected start position has come back (or DRAIN_LIMIT
    // runs out), then let the latency pass so no item is still in flight.
    task automatic drain();
        int unsigned waited;
        waited = 0;
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_starts.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Receiver: alternate stall runs and free runs. Free runs are sometimes long,
    // giving stretches with no back-pressure at all.
    always @(negedge clk) begin
        if (stall_left != 0) begin
            stall_left--;
        end else if (out_stall) begin
            stall_left = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 5)
                                                      : $urandom_range(50, 200);
            out_stall <= 1'b0;
        end else begin
            stall_left = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 2)
                                                      : $urandom_range(10, 40);
            out_stall <= 1'b1;
        end
    end

    // Sample both channels at the rising edge: note the accepted item first,
    // then check any accepted result, so same-edge order never matters.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall)
                sb.note_item(in_opcode, in_symbol, in_index);
            if (out_valid && !out_stall)
                sb.check_start(start_pos);
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int unsigned phase_no;
        int unsigned eff;
        int unsigned span;
        int unsigned base;
        int unsigned n_text;
        int unsigned follow_pct;
        int unsigned noise_pct;
        int unsigned j;
        int unsigned k;
        int unsigned n;
        int unsigned r;
        logic [6:0]  len_val;
        logic [4:0]  pat [PATTERN_MAX];
        logic [4:0]  sym;
        bit          calm;
        bit          long_pat;

        sb = new();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // ---------------- directed part ----------------
        write_length(7'd3);
        // Unused opcode with every payload bit high: ignore, no result.
        send_item(OP_UNUSED, 5'd31, 6'd63);
        // All-wildcard pattern; non-letters break the match vector.
        send_item(OP_TEXT, 5'd0, 6'd0);
        send_item(OP_TEXT, 5'd25, 6'd63);
        send_item(OP_TEXT, SYM_WILDCARD, 6'd0);
        send_item(OP_TEXT, 5'd31, 6'd0);
        send_item(OP_TEXT, 5'd0, 6'd0);
        send_item(OP_TEXT, 5'd1, 6'd0);
        send_item(OP_TEXT, 5'd2, 6'd0);
        // Pattern "a?z"; the top entry gets an odd stored symbol.
        send_item(OP_LOAD, 5'd0, 6'd0);
        send_item(OP_LOAD, SYM_WILDCARD, 6'd1);
        send_item(OP_LOAD, 5'd25, 6'd2);
        send_item(OP_LOAD, 5'd31, 6'd63);
        send_item(OP_TEXT, 5'd0, 6'd0);
        send_item(OP_TEXT, 5'd13, 6'd0);
        send_item(OP_TEXT, 5'd25, 6'd0);
        // Odd stored symbol in the middle: no letter can get past it.
        send_item(OP_LOAD, 5'd27, 6'd1);
        send_item(OP_TEXT, 5'd0, 6'd0);
        send_item(OP_TEXT, 5'd0, 6'd0);
        send_item(OP_TEXT, 5'd25, 6'd0);
        // Restart, restore the wildcard, match at position zero.
        send_item(OP_RESTART, 5'd0, 6'd0);
        send_item(OP_LOAD, SYM_WILDCARD, 6'd1);
        send_item(OP_TEXT, 5'd0, 6'd0);
        send_item(OP_TEXT, 5'd5, 6'd0);
        send_item(OP_TEXT, 5'd25, 6'd0);

        // ---------------- random phases ----------------
        // Each phase: drain, set the length, load a pattern, stream text that
        // mostly follows the pattern over a small alphabet, with some noise.
        phase_no = 0;
        while (items_sent < ITEM_TARGET) begin
            drain();
            case (phase_no)
                0: len_val = 7'd1;
                1: len_val = 7'd64;
                2: len_val = 7'd0;
                3: len_val = 7'd127;
                4: len_val = 7'd65;
                default: begin
                    r = $urandom_range(0, 99);
                    if (r < 75)
                        len_val = 7'($urandom_range(1, 8));
                    else if (r < 93)
                        len_val = 7'($urandom_range(9, 64));
                    else
                        len_val = 7'($urandom_range(65, 127));
                end
            endcase
            write_length(len_val);

            if (len_val == 0)
                eff = 1;
            else if (len_val > PATTERN_MAX)
                eff = PATTERN_MAX;
            else
                eff = len_val;
            long_pat   = (eff > 8);
            span       = $urandom_range(2, 3);
            base       = $urandom_range(0, LETTERS - span);
            calm       = ($urandom_range(0, 2) == 0);
            // Long windows only match when nearly every letter follows the pattern.
            follow_pct = long_pat ? 97 : $urandom_range(60, 90);
            noise_pct  = long_pat ? 2 : 12;
            n_text     = long_pat ? $urandom_range(150, 250) : $urandom_range(20, 60);

            for (k = 0; k < eff; k++) begin
                r = $urandom_range(0, 99);
                if (r < 20)
                    pat[k] = SYM_WILDCARD;
                else if (r < 23 && !long_pat)
                    pat[k] = 5'($urandom_range(27, 31));
                else
                    pat[k] = 5'(base + $urandom_range(0, span - 1));
                send_item(OP_LOAD, pat[k], 6'(k));
                if (!calm)
                    pause(pick_gap());
            end
            if ($urandom_range(0, 1) == 1)
                send_item(OP_RESTART, 5'($urandom), 6'($urandom));

            j = 0;
            for (n = 0; n < n_text && items_sent < ITEM_TARGET; n++) begin
                if ($urandom_range(0, 99) < noise_pct) begin
                    case ($urandom_range(0, 4))
                        0: send_item(OP_UNUSED, 5'($urandom), 6'($urandom));
                        1: send_item(OP_TEXT, 5'($urandom_range(26, 31)), 6'($urandom));
                        2: send_item(OP_RESTART, 5'($urandom), 6'($urandom));
                        3: send_item(OP_LOAD, 5'($urandom), 6'($urandom));
                        default: send_item(OP_TEXT, 5'($urandom), 6'($urandom));
                    endcase
                end else begin
                    if ($urandom_range(0, 99) < follow_pct && pat[j] < LETTERS)
                        sym = pat[j];
                    else
                        sym = 5'(base + $urandom_range(0, span - 1));
                    j = (j + 1) % eff;
                    send_item(OP_TEXT, sym, 6'($urandom));
                end
                if (!calm)
                    pause(pick_gap());
            end
            phase_no++;
        end

        drain();
        sb.flag_leftovers();
        if (sb.failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[wildcard_pattern_matcher_top.f]
sv/wpm_pkg.sv
sv/wpm_cell.sv
sv/wpm_obuf.sv
sv/wildcard_pattern_matcher_top.sv
tb/wildcard_pattern_matcher_top_tb.sv
